@@ rtl/core/cdq_pkg.sv @@
// Shared constants, codes and types for the circular deque.
package cdq_pkg;

    // Storage geometry
    localparam int DEPTH   = 8;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 4;

    // Stream word widths (fields packed from bit 0, padded to bytes)
    localparam int IN_BITS  = FUNC_W + DATA_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = DATA_W + STAT_W + OCC_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_RESULT
    } state_t;

    // Controller to datapath command group
    typedef struct packed {
        logic load;     // input transfer this cycle: execute the operation
    } dp_cmd_t;

endpackage

@@ rtl/core/circular_deque.sv @@
// An accepted input transfer has its result registered and shown on the output in the cycle after.
// One op per cycle while results are taken; the result register reloads in the cycle it is taken.
// Each operation that is carried out touches one slot of an 8-entry register memory and the pointers.
// Reset: asynchronous, active low; empties the deque (front 0, rear DEPTH-1, count 0).
// Slot contents are not cleared; only written slots are ever read back.
// Top level of the circular double-ended queue.
module circular_deque
    import cdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // func[1:0], push_value[33:2], zero pad
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // pop_value[31:0], status[33:32], occupancy[37:34], pad
);

    dp_cmd_t                  cmd;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] push_value;
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;

    // Input field unpack
    assign func       = s_axis_tdata[FUNC_W-1:0];
    assign push_value = s_axis_tdata[FUNC_W+DATA_W-1:FUNC_W];

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    cdq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .push_value (push_value),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    // Output field pack
    assign m_axis_tdata = {(OUT_W - OUT_BITS)'(0), occupancy, status, pop_value};

    // A refused push only happens with the deque full
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
        else $error("full refusal with occupancy below depth");

    // A refused pop only happens with the deque empty, and returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status == ST_EMPTY) |-> (occupancy == '0 && pop_value == '0))
        else $error("empty refusal with nonzero occupancy or data");

    // Occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above depth");

    // With no result pending, the input side is always open
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

endmodule

@@ rtl/core/cdq_dp.sv @@
// Deque datapath: slot memory, front/rear pointers, entry count, result register.
module cdq_dp
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [DATA_W-1:0] push_value,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [STAT_W-1:0]        status,
    output logic [OCC_W-1:0]         occupancy
);

    logic [DATA_W-1:0] slot_mem [DEPTH];

    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic signed [DATA_W-1:0] pop_value_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic [OCC_W-1:0]         occupancy_reg;

    logic              is_full;
    logic              is_empty;
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  front_inc, front_dec, rear_inc, rear_dec;

    // Modulo-DEPTH pointer neighbors
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign rear_inc  = (rear_reg == PTR_W'(DEPTH - 1)) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg == '0) ? PTR_W'(DEPTH - 1) : rear_reg - 1'b1;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Operation decode
    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = rear_inc;
        rd_addr     = front_reg;
        unique case (func)
            FN_PUSH_REAR:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = rear_inc;
                    rear_next  = rear_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = front_reg;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            FN_POP_REAR:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rear_reg;
                    rear_next  = rear_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= PTR_W'(DEPTH - 1);
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    // Slot memory write
    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_en)
        begin
            slot_mem[wr_addr] <= push_value;
        end
    end

    // Registered read and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pop_value_reg <= rd_en ? slot_mem[rd_addr] : '0;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

@@ rtl/core/cdq_ctrl.sv @@
// Deque controller: handshake state machine that issues operations to the datapath.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // result register frees up in the same cycle it is taken
                out_valid = 1'b1;
                in_ready  = out_ready;
                cmd.load  = in_valid && out_ready;
                if (out_ready && !in_valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
